FILE: hdl/bbsf_pkg.sv
// shared types and constants for the bounded byte stream fifo
package bbsf_pkg;

  localparam int CNT_W  = 13;
  localparam int BYTE_W = 8;
  localparam int TOT_W  = 64;

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 184;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL
  } state_t;

  // control strobes decoded from the sequencer state
  typedef struct packed {
    logic tready;
    logic exec;
    logic rd;
    logic fill;
  } ctrl_t;

endpackage

FILE: hdl/bounded_byte_stream_fifo_top.sv
// top level of the bounded byte stream fifo: sequencer, pointers, counters, ring memory
//
// A byte fifo of DEPTH entries with a programmable capacity and a writer close flag.
// Each request on the in_ channel carries a mode in in_tuser (push one byte, pop up to
// a count, close the writer, status only) and yields exactly one status result on the
// out_ channel, taken after the request has been applied. A request passes through the
// block in order: acceptance, pointer/count update with the ring write, the head read
// issue and the load of the result register; the single-port write and registered read
// of the ring memory call for these steps. The result register lets the next request be
// accepted while a result still waits; the block then stalls only in the result load
// step if the previous result has not been taken. Capacity is written on cfg_wen and
// must only change while the block is idle; values above DEPTH act as DEPTH, and a
// capacity lowered below the buffered count discards nothing. Bytes of the ring are
// only read after they were written, so the memory needs no clearing after reset.
module bounded_byte_stream_fifo_top #(
  parameter int DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: capacity
  input  logic                            cfg_wen,
  input  logic [bbsf_pkg::CNT_W-1:0]      cfg_wdata,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] push_byte, [20:8] pop_count, [23:21] zero
  input  logic [bbsf_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]                      in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] push_accepted, [13:1] popped_count, [21:14] front_byte, [22] front_valid,
  // [35:23] buffered_bytes, [48:36] free_room, [112:49] total_pushed,
  // [176:113] total_popped, [177] closed, [178] finished, [183:179] zero
  output logic [bbsf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import bbsf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough for index plus count and for DEPTH itself
  localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 2;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  // sequencer
  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  // request registers
  mode_t             mode_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0]  req_r;

  // stream state
  logic [AW-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [TOT_W-1:0]  pushed_r, pushed_nxt;
  logic              closed_r, closed_nxt;
  logic [CNT_W-1:0]  cap_r;

  // per-request results
  logic              acc_r, acc_nxt;
  logic [CNT_W-1:0]  popped_r, popped_nxt;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   load_out;

  // ring memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  // datapath helpers
  logic [CNT_W-1:0]  eff_cap;
  logic [SW-1:0]     tail_sum, tail_wrap, head_sum, head_wrap;
  logic              can_push;
  logic [CNT_W-1:0]  room;
  logic [BYTE_W-1:0] front;
  logic [TOT_W-1:0]  popped_tot;

  // capacity above DEPTH acts as DEPTH
  assign eff_cap = (SW'(cap_r) < DEPTH_S) ? cap_r : CNT_W'(DEPTH_S);

  // tail = (head + held) mod DEPTH, sum stays below twice DEPTH
  assign tail_sum  = SW'(head_r) + SW'(held_r);
  assign tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
  assign ram_waddr = tail_wrap[AW-1:0];

  assign can_push = !closed_r && (held_r < eff_cap);

  // pop removes the smaller of request and buffered count
  always_comb begin
    acc_nxt    = 1'b0;
    popped_nxt = '0;
    closed_nxt = closed_r;
    case (mode_r)
      MODE_PUSH: begin
        acc_nxt = can_push;
      end
      MODE_POP: begin
        popped_nxt = (req_r < held_r) ? req_r : held_r;
      end
      MODE_CLOSE: begin
        closed_nxt = 1'b1;
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  assign head_sum  = SW'(head_r) + SW'(popped_nxt);
  assign head_wrap = (head_sum >= DEPTH_S) ? (head_sum - DEPTH_S) : head_sum;
  assign head_nxt  = head_wrap[AW-1:0];
  assign held_nxt  = held_r + CNT_W'(acc_nxt) - popped_nxt;
  assign pushed_nxt = pushed_r + TOT_W'(acc_nxt);

  assign ram_we = ctrl.exec && acc_nxt;

  bbsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .re    (ctrl.rd),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: ctrl.tready = 1'b1;
      ST_EXEC: ctrl.exec   = 1'b1;
      ST_READ: ctrl.rd     = 1'b1;
      ST_FILL: ctrl.fill   = 1'b1;
      default: ctrl        = '0;
    endcase
  end

  assign in_tready = ctrl.tready;
  assign load_out  = ctrl.fill && (!out_valid_r || out_tready);

  // status fields after the update
  assign room       = (eff_cap > held_r) ? (eff_cap - held_r) : '0;
  assign front      = (held_r != '0) ? ram_rdata : '0;
  assign popped_tot = pushed_r - TOT_W'(held_r);

  always_comb begin
    out_data_nxt = {
      5'd0,
      closed_r && (held_r == '0),
      closed_r,
      popped_tot,
      pushed_r,
      room,
      held_r,
      held_r != '0,
      front,
      popped_r,
      acc_r
    };
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      held_r      <= '0;
      pushed_r    <= '0;
      closed_r    <= 1'b0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (ctrl.exec) begin
        head_r   <= head_nxt;
        held_r   <= held_nxt;
        pushed_r <= pushed_nxt;
        closed_r <= closed_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.tready && in_tvalid) begin
      mode_r <= mode_t'(in_tuser);
      byte_r <= in_tdata[BYTE_W-1:0];
      req_r  <= in_tdata[BYTE_W +: CNT_W];
    end
    if (ctrl.exec) begin
      acc_r    <= acc_nxt;
      popped_r <= popped_nxt;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hdl/bbsf_ram.sv
// generic single write port ram with registered read
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/tb.sv
// testbench for the bounded byte stream fifo: predictor, stream driver, result checker
`timescale 1ns / 100ps

module tb;
  import bbsf_pkg::*;

  localparam int DEPTH = 4096;
  localparam logic [CNT_W-1:0] DEPTH_CNT = 13'd4096;
  localparam int STATUS_W = 179;
  // cycles without any handshake before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // pause after the last result before a capacity write or the end of the run
  localparam int SETTLE_CYCLES = 8;

  // one request as it travels on the in_ channel
  typedef struct {
    mode_t          mode;
    logic [7:0]     data;
    logic [CNT_W-1:0] count;
  } fifo_req_t;

  // status result, packed so that push_accepted lands in bit 0 of out_tdata
  typedef struct packed {
    logic             finished;
    logic             closed;
    logic [TOT_W-1:0] total_popped;
    logic [TOT_W-1:0] total_pushed;
    logic [CNT_W-1:0] free_room;
    logic [CNT_W-1:0] buffered_bytes;
    logic             front_valid;
    logic [7:0]       front_byte;
    logic [CNT_W-1:0] popped_count;
    logic             push_accepted;
  } fifo_status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  always #1 clk = ~clk;

  bounded_byte_stream_fifo_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // mirror of the fifo state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [7:0]       fifo_mem [DEPTH];
  logic [11:0]      fifo_head = '0;
  logic [CNT_W-1:0] fifo_held = '0;
  logic [TOT_W-1:0] fifo_pushed_total = '0;
  logic             fifo_closed = 1'b0;
  logic [CNT_W-1:0] fifo_capacity = CAP_RESET;

  fifo_req_t    request_q[$];   // requests not yet offered
  fifo_status_t status_q[$];    // status results still owed by the block

  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int pushes_dropped = 0;
  int pushes_refused_full = 0;

  // applies one request to the mirror and returns the status it must produce
  function automatic fifo_status_t next_status(input fifo_req_t req);
    fifo_status_t     st;
    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] taken;
    st = '0;
    // capacity above the ring depth behaves as the ring depth
    eff_cap = (fifo_capacity < DEPTH_CNT) ? fifo_capacity : DEPTH_CNT;
    case (req.mode)
      MODE_PUSH: begin
        if (!fifo_closed && fifo_held < eff_cap) begin
          fifo_mem[fifo_head + fifo_held[11:0]] = req.data;
          fifo_held = fifo_held + 13'd1;
          fifo_pushed_total = fifo_pushed_total + 64'd1;
          st.push_accepted = 1'b1;
        end else begin
          pushes_dropped++;
          if (!fifo_closed) pushes_refused_full++;
        end
      end
      MODE_POP: begin
        taken = (req.count < fifo_held) ? req.count : fifo_held;
        fifo_head = fifo_head + taken[11:0];
        fifo_held = fifo_held - taken;
        st.popped_count = taken;
      end
      MODE_CLOSE: begin
        fifo_closed = 1'b1;
      end
      default: begin
      end
    endcase
    st.front_valid    = (fifo_held != '0);
    st.front_byte     = (fifo_held != '0) ? fifo_mem[fifo_head] : 8'h00;
    st.buffered_bytes = fifo_held;
    // a capacity lowered below the held count reads as no room at all
    st.free_room      = (eff_cap > fifo_held) ? eff_cap - fifo_held : '0;
    st.total_pushed   = fifo_pushed_total;
    st.total_popped   = fifo_pushed_total - TOT_W'(fifo_held);
    st.closed         = fifo_closed;
    st.finished       = fifo_closed && (fifo_held == '0);
    return st;
  endfunction

  task automatic check_field(input string name, input logic [TOT_W-1:0] want,
                             input logic [TOT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: offers the oldest pending request, random gap after each
  // ---------------------------------------------------------------------------
  fifo_req_t cur_req;
  bit        have_item = 1'b0;
  bit        req_taken = 1'b0;
  int        req_gap = 0;
  bit        quiet_link = 1'b0;   // no idling on either side while set

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      status_q.insert(status_q.size(), next_status(cur_req));
      requests_sent++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        have_item = 1'b0;
        req_gap = quiet_link ? 0 : $urandom_range(0, 6);
      end
      if (!have_item) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q[0];
          request_q.delete(0);
          have_item = 1'b1;
        end
      end
      // valid stays high straight through back-to-back requests
      in_tvalid <= have_item;
      if (have_item) begin
        in_tdata <= {3'b000, cur_req.count, cur_req.data};
        in_tuser <= cur_req.mode;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: ready with random gaps, plus an optional long hold-off
  // ---------------------------------------------------------------------------
  bit res_taken = 1'b0;
  int res_gap = 0;
  int sink_stall_len = 0;

  always @(posedge clk) begin : result_monitor
    fifo_status_t got;
    fifo_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      res_taken = 1'b1;
      got = fifo_status_t'(out_tdata[STATUS_W-1:0]);
      if (status_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: status result with nothing outstanding, got %0h", $time, got);
      end else begin
        want = status_q[0];
        status_q.delete(0);
        results_checked++;
        check_field("push_accepted",  want.push_accepted,  got.push_accepted);
        check_field("popped_count",   want.popped_count,   got.popped_count);
        check_field("front_byte",     want.front_byte,     got.front_byte);
        check_field("front_valid",    want.front_valid,    got.front_valid);
        check_field("buffered_bytes", want.buffered_bytes, got.buffered_bytes);
        check_field("free_room",      want.free_room,      got.free_room);
        check_field("total_pushed",   want.total_pushed,   got.total_pushed);
        check_field("total_popped",   want.total_popped,   got.total_popped);
        check_field("closed",         want.closed,         got.closed);
        check_field("finished",       want.finished,       got.finished);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) begin
        res_taken = 1'b0;
        res_gap = quiet_link ? 0 : $urandom_range(0, 6);
      end
      // the long hold-off lets the block fill up and push back on in_tready
      if (sink_stall_len > 0) begin
        sink_stall_len--;
        out_tready <= 1'b0;
      end else if (res_gap > 0) begin
        res_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any handshake or register write counts as progress
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, status_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(input mode_t m, input logic [7:0] d, input logic [CNT_W-1:0] c);
    fifo_req_t r;
    r.mode  = m;
    r.data  = d;
    r.count = c;
    request_q.insert(request_q.size(), r);
  endtask

  // sender holds back until every owed result is in, then lets the block settle
  task automatic wait_idle();
    while (request_q.size() != 0 || have_item || status_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    fifo_capacity = value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // mostly pushes and short pops with random content; never closes the writer
  task automatic add_random(input int n);
    int          pick;
    logic [7:0]  d;
    logic [CNT_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      d = 8'($urandom_range(0, 255));
      c = CNT_W'($urandom_range(0, 8191));
      if (pick < 55) begin
        add_req(MODE_PUSH, d, c);
      end else if (pick < 85) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      c = CNT_W'($urandom_range(0, 3));
        else if (pick < 9) c = CNT_W'($urandom_range(0, 20));
        add_req(MODE_POP, d, c);
      end else begin
        add_req(MODE_STATUS, d, c);
      end
    end
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] phase_cap [8];
    phase_cap = '{13'd3, 13'd16, 13'd1, 13'd0, 13'd64, 13'd2, 13'd8191, 13'd5000};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset capacity, empty fifo, byte extremes, zero and oversized pops
    add_req(MODE_STATUS, 8'h00, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd0);
    add_req(MODE_POP,    8'hff, 13'd4096);
    add_req(MODE_PUSH,   8'h00, 13'h1fff);
    add_req(MODE_PUSH,   8'hff, 13'd0);
    add_req(MODE_PUSH,   8'ha5, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd1);
    add_req(MODE_POP,    8'hff, 13'h1fff);
    add_req(MODE_PUSH,   8'h5a, 13'd0);
    add_req(MODE_PUSH,   8'h3c, 13'd0);
    wait_idle();

    // capacity lowered below the held count: nothing lost, pushes refused
    write_capacity(13'd1);
    add_req(MODE_PUSH,   8'h11, 13'd0);
    add_req(MODE_STATUS, 8'h00, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd1);
    add_req(MODE_PUSH,   8'h22, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd1);
    add_req(MODE_PUSH,   8'h33, 13'd0);
    wait_idle();
    write_capacity(13'd0);
    add_req(MODE_PUSH,   8'h44, 13'd0);
    add_req(MODE_POP,    8'h00, 13'd1);
    add_req(MODE_PUSH,   8'h55, 13'd0);
    wait_idle();
    // capacity beyond the ring depth reads back as the ring depth
    write_capacity(13'h1fff);
    add_req(MODE_STATUS, 8'h00, 13'd0);
    add_req(MODE_PUSH,   8'h66, 13'd0);
    wait_idle();

    // random phases, each under its own capacity, with full stops between them
    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      quiet_link = (p == 4);
      add_random(145);
      if (p == 1) sink_stall_len = 400;
      wait_idle();
    end
    quiet_link = 1'b0;

    // writer closed last, since nothing reopens it short of a reset
    add_req(MODE_CLOSE,  8'h00, 13'd0);
    add_req(MODE_PUSH,   8'h77, 13'd0);
    add_req(MODE_CLOSE,  8'hff, 13'h1fff);
    add_req(MODE_POP,    8'h00, 13'd1);
    add_req(MODE_STATUS, 8'h00, 13'd0);
    add_req(MODE_POP,    8'h00, 13'h1fff);
    add_req(MODE_POP,    8'h00, 13'd0);
    add_req(MODE_PUSH,   8'h88, 13'd0);
    add_random(20);
    wait_idle();

    $display("checked %0d status results for %0d requests, capacities 0 to 8191",
             results_checked, requests_sent);
    $display("%0d bytes stored, %0d pushes dropped (%0d on a full fifo), writer closed at the end",
             fifo_pushed_total, pushes_dropped, pushes_refused_full);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bbsf_pkg.sv
hdl/bbsf_ram.sv
hdl/bounded_byte_stream_fifo_top.sv
tb/tb.sv
